// ===== rtl/core/biquad_direct_form1_fixed_assert.svh =====
// Assertion macros shared by the biquad core modules
`ifndef BIQUAD_DIRECT_FORM1_FIXED_ASSERT_SVH
`define BIQUAD_DIRECT_FORM1_FIXED_ASSERT_SVH

`ifndef SYNTH
`define BQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BQ_ASSERT_IMP(lbl, ante, cons)
`define BQ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/bq_df1_pkg.sv =====
// Shared types and constants of the biquad core
`timescale 1ns / 1ps

package bq_df1_pkg;

    localparam int DATA_W  = 16;
    localparam int CH_W    = 3;
    localparam int RES_W   = 14;
    localparam int CNT_W   = 32;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int PC_W    = 4;
    localparam int OP_W    = 17;
    localparam int PROD_W  = 34;
    localparam int ACC_W   = 36;

    // register map, index = paddr[4:2]
    localparam logic [2:0] REG_B0  = 3'd0;
    localparam logic [2:0] REG_B1  = 3'd1;
    localparam logic [2:0] REG_B2  = 3'd2;
    localparam logic [2:0] REG_A1  = 3'd3;
    localparam logic [2:0] REG_A2  = 3'd4;
    localparam logic [2:0] REG_WET = 3'd5;

    localparam logic [DATA_W-1:0] B0_RESET = 16'd16384;
    localparam logic [DATA_W-1:0] WET_ONE  = 16'd32768;

    localparam logic signed [ACC_W-1:0] SUM_MAX  = 36'sd536870911;
    localparam logic signed [ACC_W-1:0] SUM_MIN  = -36'sd536870912;
    localparam logic signed [ACC_W-1:0] MIX_BIAS = 36'sd32767;

    localparam logic [PC_W-1:0] PC_OUT = 4'd8;

    typedef enum logic [2:0] {
        MA_ZERO,
        MA_B0,
        MA_B1,
        MA_B2,
        MA_A1,
        MA_A2,
        MA_WET,
        MA_DRY
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_X,
        MB_X1,
        MB_X2,
        MB_Y1,
        MB_Y2,
        MB_Y
    } mul_b_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_RES,
        ACC_ADD,
        ACC_SUB,
        ACC_PROD
    } acc_op_t;

    typedef struct packed {
        logic             jump;
        logic [PC_W-1:0]  target;
        mul_a_t           mul_a;
        mul_b_t           mul_b;
        acc_op_t          acc_op;
        logic             commit;
        logic             last;
    } ucode_t;

    typedef struct packed {
        logic   en;
        logic   load;
        ucode_t uc;
    } ctl_t;

    typedef struct packed {
        logic skip;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] b0;
        logic signed [DATA_W-1:0] b1;
        logic signed [DATA_W-1:0] b2;
        logic signed [DATA_W-1:0] a1;
        logic signed [DATA_W-1:0] a2;
        logic        [DATA_W-1:0] wet;
    } coef_t;

endpackage

// ===== rtl/core/bq_df1_cfg.sv =====
// APB register block: filter taps and wet level
`timescale 1ns / 1ps

module bq_df1_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bq_df1_pkg::PADDR_W-1:0]   paddr,
    input  logic [bq_df1_pkg::PDATA_W-1:0]   pwdata,
    output logic [bq_df1_pkg::PDATA_W-1:0]   prdata,
    output logic                             pready,
    output bq_df1_pkg::coef_t                coef
);
    import bq_df1_pkg::*;

    logic [2:0]        idx;
    logic              wr;
    logic [DATA_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg, wet_reg;
    logic [DATA_W-1:0] rd_val;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg  <= B0_RESET;
            b1_reg  <= '0;
            b2_reg  <= '0;
            a1_reg  <= '0;
            a2_reg  <= '0;
            wet_reg <= WET_ONE;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_B0:  b0_reg  <= pwdata[DATA_W-1:0];
                REG_B1:  b1_reg  <= pwdata[DATA_W-1:0];
                REG_B2:  b2_reg  <= pwdata[DATA_W-1:0];
                REG_A1:  a1_reg  <= pwdata[DATA_W-1:0];
                REG_A2:  a2_reg  <= pwdata[DATA_W-1:0];
                REG_WET: wet_reg <= pwdata[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_B0:  rd_val = b0_reg;
            REG_B1:  rd_val = b1_reg;
            REG_B2:  rd_val = b2_reg;
            REG_A1:  rd_val = a1_reg;
            REG_A2:  rd_val = a2_reg;
            REG_WET: rd_val = wet_reg;
            default: rd_val = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-DATA_W){1'b0}}, rd_val};

    assign coef.b0  = $signed(b0_reg);
    assign coef.b1  = $signed(b1_reg);
    assign coef.b2  = $signed(b2_reg);
    assign coef.a1  = $signed(a1_reg);
    assign coef.a2  = $signed(a2_reg);
    assign coef.wet = wet_reg;

endmodule

// ===== rtl/core/bq_df1_seq.sv =====
// Microcode sequencer: program ROM, step counter and handshake control
`timescale 1ns / 1ps
`include "biquad_direct_form1_fixed_assert.svh"

module bq_df1_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  bq_df1_pkg::dp_stat_t  stat,
    output bq_df1_pkg::ctl_t      ctl
);
    import bq_df1_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

    // one word per step; the sum is built in steps 0..5, committed in 6,
    // mixed in 7 and 8
    function automatic ucode_t rom_word(input logic [PC_W-1:0] pc);
        ucode_t w;
        w.jump   = 1'b0;
        w.target = '0;
        w.mul_a  = MA_ZERO;
        w.mul_b  = MB_X;
        w.acc_op = ACC_HOLD;
        w.commit = 1'b0;
        w.last   = 1'b0;
        unique case (pc)
            4'd0:
            begin
                w.mul_a  = MA_B0;
                w.mul_b  = MB_X;
                w.acc_op = ACC_RES;
                w.jump   = 1'b1;      // channel out of range: straight to output
                w.target = PC_OUT;
            end
            4'd1:
            begin
                w.mul_a  = MA_B1;
                w.mul_b  = MB_X1;
                w.acc_op = ACC_ADD;
            end
            4'd2:
            begin
                w.mul_a  = MA_B2;
                w.mul_b  = MB_X2;
                w.acc_op = ACC_ADD;
            end
            4'd3:
            begin
                w.mul_a  = MA_A1;
                w.mul_b  = MB_Y1;
                w.acc_op = ACC_ADD;
            end
            4'd4:
            begin
                w.mul_a  = MA_A2;
                w.mul_b  = MB_Y2;
                w.acc_op = ACC_SUB;
            end
            4'd5:
            begin
                w.mul_a  = MA_DRY;
                w.mul_b  = MB_X;
                w.acc_op = ACC_SUB;
            end
            4'd6:
            begin
                w.acc_op = ACC_PROD;     // acc takes the dry product
                w.commit = 1'b1;
            end
            4'd7:
            begin
                w.mul_a  = MA_WET;
                w.mul_b  = MB_Y;
            end
            PC_OUT:
            begin
                w.last   = 1'b1;
            end
            default:
            begin
                w.last   = 1'b1;
            end
        endcase
        return w;
    endfunction

    seq_state_t      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          uc;
    logic            running;
    logic            step_en;
    logic            in_acc;

    assign running   = (state_reg == ST_RUN);
    assign uc        = rom_word(pc_reg);
    assign step_en   = running && (!uc.last || stat.out_free);
    assign src_stall = running && !(uc.last && stat.out_free);
    assign in_acc    = src_valid && !src_stall;

    assign ctl.en   = step_en;
    assign ctl.load = in_acc;
    assign ctl.uc   = uc;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                end
            end
            ST_RUN:
            begin
                if (step_en)
                begin
                    priority if (uc.last)
                    begin
                        pc_next    = '0;
                        state_next = in_acc ? ST_RUN : ST_IDLE;
                    end
                    else if (uc.jump && stat.skip)
                        pc_next = uc.target;
                    else
                        pc_next = pc_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                pc_next    = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    `BQ_ASSERT_IMP(a_idle_pc_zero, state_reg == ST_IDLE, pc_reg == '0)
    `BQ_ASSERT_IMP(a_run_accept_last, running && in_acc, uc.last && step_en)
    `BQ_ASSERT_NXT(a_stall_holds_pc, running && !step_en, $stable(pc_reg) && state_reg == ST_RUN)

endmodule

// ===== rtl/core/bq_df1_dp.sv =====
// Datapath: shared multiplier, accumulator, channel state and output register
`timescale 1ns / 1ps
`include "biquad_direct_form1_fixed_assert.svh"

module bq_df1_dp #(
    parameter int CHANNELS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bq_df1_pkg::ctl_t                      ctl,
    input  bq_df1_pkg::coef_t                     coef,
    input  logic signed [bq_df1_pkg::DATA_W-1:0]  sample_in,
    input  logic        [bq_df1_pkg::CH_W-1:0]    channel,
    input  logic                                  bypass,
    input  logic                                  block_end,
    output bq_df1_pkg::dp_stat_t                  stat,
    output logic signed [bq_df1_pkg::DATA_W-1:0]  sample_out,
    output logic                                  clipped,
    output logic        [bq_df1_pkg::CNT_W-1:0]   clip_total,
    output logic                                  block_end_out,
    output logic                                  dst_valid,
    input  logic                                  dst_stall
);
    import bq_df1_pkg::*;

    localparam int DEPTH = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] x1;
        logic signed [DATA_W-1:0] x2;
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W-1:0] y2;
        logic        [RES_W-1:0]  res;
        logic        [CNT_W-1:0]  cnt;
    } chan_state_t;

    chan_state_t st_reg [DEPTH];
    chan_state_t cur;

    // latched beat
    logic signed [DATA_W-1:0] x_reg;
    logic                     byp_reg;
    logic                     blk_reg;
    logic                     skip_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     ch_ok;

    logic signed [OP_W-1:0]   a_op, b_op;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  prod_ext;

    logic [DATA_W-1:0]        wet_eff, dry;

    logic                     clip_hi, clip_lo, clip;
    logic signed [29:0]       clamped;
    logic signed [DATA_W-1:0] y_new;
    logic [CNT_W-1:0]         cnt_new;

    logic signed [DATA_W-1:0] y_reg;
    logic                     clip_reg;
    logic [CNT_W-1:0]         total_reg;

    logic signed [ACC_W-1:0]  mix_sum, mix_rnd;
    logic signed [DATA_W-1:0] mixed;

    logic signed [DATA_W-1:0] sample_out_reg;
    logic                     clipped_reg;
    logic [CNT_W-1:0]         clip_total_reg;
    logic                     block_end_out_reg;
    logic                     out_valid_reg, out_valid_next;

    assign ch_ok = ({29'd0, channel} < 32'(CHANNELS));

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg    <= sample_in;
            byp_reg  <= bypass;
            blk_reg  <= block_end;
            skip_reg <= !ch_ok;
            idx_reg  <= ch_ok ? channel[IDX_W-1:0] : '0;
        end
    end

    assign cur = st_reg[idx_reg];

    assign wet_eff = (coef.wet > WET_ONE) ? WET_ONE : coef.wet;
    assign dry     = WET_ONE - wet_eff;

    always_comb
    begin
        unique case (ctl.uc.mul_a)
            MA_ZERO: a_op = '0;
            MA_B0:   a_op = OP_W'(coef.b0);
            MA_B1:   a_op = OP_W'(coef.b1);
            MA_B2:   a_op = OP_W'(coef.b2);
            MA_A1:   a_op = OP_W'(coef.a1);
            MA_A2:   a_op = OP_W'(coef.a2);
            MA_WET:  a_op = $signed({1'b0, wet_eff});
            MA_DRY:  a_op = $signed({1'b0, dry});
            default: a_op = '0;
        endcase
    end

    always_comb
    begin
        unique case (ctl.uc.mul_b)
            MB_X:    b_op = OP_W'(x_reg);
            MB_X1:   b_op = OP_W'(cur.x1);
            MB_X2:   b_op = OP_W'(cur.x2);
            MB_Y1:   b_op = OP_W'(cur.y1);
            MB_Y2:   b_op = OP_W'(cur.y2);
            MB_Y:    b_op = OP_W'(y_reg);
            default: b_op = '0;
        endcase
    end

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        unique case (ctl.uc.acc_op)
            ACC_HOLD: acc_next = acc_reg;
            ACC_RES:  acc_next = $signed({{(ACC_W-RES_W){1'b0}}, cur.res});
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            ACC_PROD: acc_next = prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg <= a_op * b_op;
            acc_reg  <= acc_next;
        end
    end

    // clamp to 30 bits; low 14 bits are the new residue, the rest is y (floor)
    assign clip_hi = (acc_reg > SUM_MAX);
    assign clip_lo = (acc_reg < SUM_MIN);
    assign clip    = clip_hi || clip_lo;

    always_comb
    begin
        priority if (clip_hi)
            clamped = SUM_MAX[29:0];
        else if (clip_lo)
            clamped = SUM_MIN[29:0];
        else
            clamped = acc_reg[29:0];
    end

    assign y_new   = clamped[29:RES_W];
    assign cnt_new = (clip && (cur.cnt != '1)) ? cur.cnt + 1'b1 : cur.cnt;

    always_ff @(posedge clk)
    begin
        if (ctl.en && ctl.uc.commit)
        begin
            y_reg     <= y_new;
            clip_reg  <= clip;
            total_reg <= cnt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                st_reg[i] <= '0;
        end
        else if (ctl.en && ctl.uc.commit)
        begin
            st_reg[idx_reg].x1  <= x_reg;
            st_reg[idx_reg].x2  <= cur.x1;
            st_reg[idx_reg].y1  <= y_new;
            st_reg[idx_reg].y2  <= cur.y1;
            st_reg[idx_reg].res <= clamped[RES_W-1:0];
            st_reg[idx_reg].cnt <= cnt_new;
        end
    end

    // dry product in acc, wet product in prod; divide by 32768 toward zero
    assign mix_sum = acc_reg + prod_ext;
    assign mix_rnd = mix_sum[ACC_W-1] ? mix_sum + MIX_BIAS : mix_sum;
    assign mixed   = mix_rnd[30:15];

    always_ff @(posedge clk)
    begin
        if (ctl.en && ctl.uc.last)
        begin
            sample_out_reg    <= (skip_reg || byp_reg) ? x_reg : mixed;
            clipped_reg       <= skip_reg ? 1'b0 : clip_reg;
            clip_total_reg    <= skip_reg ? '0 : total_reg;
            block_end_out_reg <= blk_reg;
        end
    end

    always_comb
    begin
        priority if (ctl.en && ctl.uc.last)
            out_valid_next = 1'b1;
        else if (!dst_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign stat.skip     = skip_reg;
    assign stat.out_free = !out_valid_reg || !dst_stall;

    assign sample_out    = sample_out_reg;
    assign clipped       = clipped_reg;
    assign clip_total    = clip_total_reg;
    assign block_end_out = block_end_out_reg;
    assign dst_valid     = out_valid_reg;

    `BQ_ASSERT_IMP(a_commit_in_range, ctl.en && ctl.uc.commit, !skip_reg)
    `BQ_ASSERT_IMP(a_no_overwrite, ctl.en && ctl.uc.last, !out_valid_reg || !dst_stall)
    `BQ_ASSERT_NXT(a_skip_reports_zero, ctl.en && ctl.uc.last && skip_reg, !clipped && clip_total == '0)

endmodule

// ===== rtl/core/biquad_direct_form1_fixed.sv =====
// Each accepted input beat runs the 9-word microprogram, which shares one 17x17 multiplier
// for the five taps and the mix; a channel outside the configured range jumps straight to
// the output step, and the result beat is presented from the output register.
// The next input beat is taken on the cycle the current result enters the output register.
// Reset (rst_n low, asynchronous) clears all channel history, residues and clip counts
// and loads b0 = 1.0, other taps 0, wet level fully filtered.
`timescale 1ns / 1ps

module biquad_direct_form1_fixed #(
    parameter int CHANNELS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bq_df1_pkg::PADDR_W-1:0]        paddr,
    input  logic [bq_df1_pkg::PDATA_W-1:0]        pwdata,
    output logic [bq_df1_pkg::PDATA_W-1:0]        prdata,
    output logic                                  pready,
    input  logic signed [bq_df1_pkg::DATA_W-1:0]  sample_in,
    input  logic        [bq_df1_pkg::CH_W-1:0]    channel,
    input  logic                                  bypass,
    input  logic                                  block_end,
    input  logic                                  src_valid,
    output logic                                  src_stall,
    output logic signed [bq_df1_pkg::DATA_W-1:0]  sample_out,
    output logic                                  clipped,
    output logic        [bq_df1_pkg::CNT_W-1:0]   clip_total,
    output logic                                  block_end_out,
    output logic                                  dst_valid,
    input  logic                                  dst_stall
);
    import bq_df1_pkg::*;

    coef_t    coef;
    ctl_t     ctl;
    dp_stat_t stat;

    bq_df1_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    bq_df1_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    bq_df1_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .coef          (coef),
        .sample_in     (sample_in),
        .channel       (channel),
        .bypass        (bypass),
        .block_end     (block_end),
        .stat          (stat),
        .sample_out    (sample_out),
        .clipped       (clipped),
        .clip_total    (clip_total),
        .block_end_out (block_end_out),
        .dst_valid     (dst_valid),
        .dst_stall     (dst_stall)
    );

endmodule

// ===== tb/biquad_direct_form1_fixed_tb.sv =====
// Self-checking bench for the multichannel direct form I biquad with error feedback
`timescale 1ns / 1ps

module biquad_direct_form1_fixed_tb;

    import bq_df1_pkg::*;

    localparam int          N_CH        = 8;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_BEATS = 230;

    typedef enum {TAPS_EDGE, TAPS_ANY, TAPS_MILD} tap_style_t;

    typedef struct {
        logic signed [DATA_W-1:0] sample;
        logic                     clip;
        logic        [CNT_W-1:0]  total;
        logic                     blk;
    } filter_beat_t;

    // Channel bank: per-channel history, residue and clip count, plus expected beats
    class biquad_channel_bank;
        logic signed [DATA_W-1:0] b0, b1, b2, a1, a2;
        logic        [DATA_W-1:0] wet;
        logic signed [DATA_W-1:0] x1 [N_CH];
        logic signed [DATA_W-1:0] x2 [N_CH];
        logic signed [DATA_W-1:0] y1 [N_CH];
        logic signed [DATA_W-1:0] y2 [N_CH];
        logic        [RES_W-1:0]  res [N_CH];
        logic        [CNT_W-1:0]  clips [N_CH];
        filter_beat_t             awaited [$];
        int unsigned              faults;
        int unsigned              checked;
        int unsigned              clamped;

        function new();
            b0  = B0_RESET;
            b1  = '0;
            b2  = '0;
            a1  = '0;
            a2  = '0;
            wet = WET_ONE;
            for (int i = 0; i < N_CH; i++)
            begin
                x1[i]    = '0;
                x2[i]    = '0;
                y1[i]    = '0;
                y2[i]    = '0;
                res[i]   = '0;
                clips[i] = '0;
            end
            faults  = 0;
            checked = 0;
            clamped = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_B0:  b0  = val;
                REG_B1:  b1  = val;
                REG_B2:  b2  = val;
                REG_A1:  a1  = val;
                REG_A2:  a2  = val;
                REG_WET: wet = val;
                default: ;
            endcase
        endfunction

        function void take_sample(logic signed [DATA_W-1:0] x, logic [CH_W-1:0] ch,
                                  logic byp, logic blk);
            filter_beat_t e;
            longint       acc;
            longint       biased;
            longint       y;
            longint       wv;
            longint       mixed;
            logic         clip;
            clip  = 1'b0;
            e.blk = blk;
            if (ch >= N_CH)
            begin
                e.sample = x;
                e.clip   = 1'b0;
                e.total  = '0;
                awaited.push_back(e);
                return;
            end
            acc = longint'(res[ch]) + longint'(x) * longint'(b0)
                + longint'(x1[ch]) * longint'(b1) + longint'(x2[ch]) * longint'(b2)
                - longint'(y1[ch]) * longint'(a1) - longint'(y2[ch]) * longint'(a2);
            if (acc > 64'sd536870911)
            begin
                acc  = 64'sd536870911;
                clip = 1'b1;
            end
            else if (acc < -64'sd536870912)
            begin
                acc  = -64'sd536870912;
                clip = 1'b1;
            end
            if (clip && clips[ch] != '1)
                clips[ch] = clips[ch] + 1;
            // floor shift: bias to non-negative, split fraction and integer part
            biased  = acc + 64'sd536870912;
            res[ch] = RES_W'(biased);
            y       = (biased >>> RES_W) - 64'sd32768;
            x2[ch]  = x1[ch];
            x1[ch]  = x;
            y2[ch]  = y1[ch];
            y1[ch]  = DATA_W'(y);
            wv      = (wet > WET_ONE) ? 64'sd32768 : longint'(wet);
            mixed   = (y * wv + longint'(x) * (64'sd32768 - wv)) / 64'sd32768;
            e.sample = byp ? x : DATA_W'(mixed);
            e.clip   = clip;
            e.total  = clips[ch];
            awaited.push_back(e);
        endfunction

        function void match_output(logic signed [DATA_W-1:0] s, logic c,
                                   logic [CNT_W-1:0] tot, logic be);
            filter_beat_t e;
            if (awaited.size() == 0)
            begin
                $error("output beat arrived with no sample pending");
                faults++;
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (e.clip)
                clamped++;
            if (s !== e.sample)
            begin
                $error("sample_out: expected %0d, got %0d", e.sample, s);
                faults++;
            end
            if (c !== e.clip)
            begin
                $error("clipped: expected %0d, got %0d", e.clip, c);
                faults++;
            end
            if (tot !== e.total)
            begin
                $error("clip_total: expected %0d, got %0d", e.total, tot);
                faults++;
            end
            if (be !== e.blk)
            begin
                $error("block_end_out: expected %0d, got %0d", e.blk, be);
                faults++;
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      psel       = 1'b0;
    logic                      penable    = 1'b0;
    logic                      pwrite     = 1'b0;
    logic [PADDR_W-1:0]        paddr      = '0;
    logic [PDATA_W-1:0]        pwdata     = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic signed [DATA_W-1:0]  sample_in  = '0;
    logic        [CH_W-1:0]    channel    = '0;
    logic                      bypass     = 1'b0;
    logic                      block_end  = 1'b0;
    logic                      src_valid  = 1'b0;
    logic                      src_stall;
    logic signed [DATA_W-1:0]  sample_out;
    logic                      clipped;
    logic        [CNT_W-1:0]   clip_total;
    logic                      block_end_out;
    logic                      dst_valid;
    logic                      dst_stall  = 1'b0;

    biquad_channel_bank bank = new();
    int unsigned        cycle_count = 0;
    int unsigned        settings_used = 0;
    int unsigned        bypassed = 0;

    biquad_direct_form1_fixed #(
        .CHANNELS(N_CH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_in    (sample_in),
        .channel      (channel),
        .bypass       (bypass),
        .block_end    (block_end),
        .src_valid    (src_valid),
        .src_stall    (src_stall),
        .sample_out   (sample_out),
        .clipped      (clipped),
        .clip_total   (clip_total),
        .block_end_out(block_end_out),
        .dst_valid    (dst_valid),
        .dst_stall    (dst_stall)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
            bank.match_output(sample_out, clipped, clip_total, block_end_out);
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [DATA_W-1:0] pick_tap(tap_style_t style);
        case (style)
            TAPS_EDGE:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            TAPS_ANY:  return DATA_W'($urandom_range(0, 65535));
            default:   return DATA_W'($urandom_range(0, 16384)) - 16'd8192;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_wet(int ph);
        case (ph % 5)
            0:       return WET_ONE;
            1:       return DATA_W'($urandom_range(0, 32768));
            2:       return 16'd0;
            3:       return DATA_W'($urandom_range(32769, 65535));
            default: return DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return -16'sh8000;
            2:       return DATA_W'($urandom_range(0, 511)) - 16'sd256;
            default: return DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int k;
        forever
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                dst_stall <= 1'b0;
                repeat ($urandom_range(100, 300)) @(posedge clk);
            end
            else
            begin
                k = idle_len();
                if (k > 0)
                begin
                    dst_stall <= 1'b1;
                    repeat (k) @(posedge clk);
                end
                dst_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom_range(0, 65535)), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bank.set_register(idx, val);
        @(posedge clk);
    endtask

    task automatic write_all(logic [DATA_W-1:0] nb0, logic [DATA_W-1:0] nb1,
                             logic [DATA_W-1:0] nb2, logic [DATA_W-1:0] na1,
                             logic [DATA_W-1:0] na2, logic [DATA_W-1:0] nwet);
        write_reg(REG_B0, nb0);
        write_reg(REG_B1, nb1);
        write_reg(REG_B2, nb2);
        write_reg(REG_A1, na1);
        write_reg(REG_A2, na2);
        write_reg(REG_WET, nwet);
        settings_used++;
    endtask

    task automatic send_sample(logic signed [DATA_W-1:0] x, logic [CH_W-1:0] ch,
                               logic byp, logic blk, int gap);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        sample_in <= x;
        channel   <= ch;
        bypass    <= byp;
        block_end <= blk;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        bank.take_sample(x, ch, byp, blk);
        if (byp)
            bypassed++;
    endtask

    // drop valid and wait for every pending beat to come back
    task automatic drain();
        src_valid <= 1'b0;
        do
            @(posedge clk);
        while (bank.pending() != 0);
    endtask

    initial
    begin
        tap_style_t style;
        int         quiet;
        int         gap;
        quiet = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset taps: unity pass-through
        send_sample(16'sh7FFF, 3'd0, 1'b0, 1'b0, 0);
        send_sample(-16'sh8000, 3'd0, 1'b0, 1'b0, 0);
        send_sample(16'sh0000, 3'd0, 1'b0, 1'b1, 0);
        send_sample(16'sd12345, 3'd7, 1'b1, 1'b0, 0);
        send_sample(-16'sd1, 3'd7, 1'b0, 1'b1, 0);
        drain();

        // hot taps with a1 at the negative rail and a2 at the positive rail, wet above one
        write_all(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'd40000);
        send_sample(16'sh7FFF, 3'd1, 1'b0, 1'b0, 0);
        send_sample(16'sh7FFF, 3'd1, 1'b0, 1'b0, 0);
        send_sample(-16'sh8000, 3'd1, 1'b0, 1'b0, 0);
        send_sample(-16'sh8000, 3'd1, 1'b1, 1'b0, 0);
        send_sample(16'sd100, 3'd2, 1'b0, 1'b0, 0);
        send_sample(-16'sd100, 3'd2, 1'b0, 1'b1, 0);
        drain();

        // fully dry
        write_all(16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'd0);
        send_sample(16'sh7FFF, 3'd3, 1'b0, 1'b0, 0);
        send_sample(-16'sh8000, 3'd3, 1'b0, 1'b0, 0);
        send_sample(16'sd5, 3'd3, 1'b1, 1'b0, 0);
        drain();

        // odd mix so negative results truncate toward zero
        write_all(16'd16384, -16'sd8192, 16'd8192, -16'sd16384, 16'd8192, 16'd16383);
        send_sample(-16'sh8000, 3'd4, 1'b0, 1'b0, 0);
        send_sample(-16'sd3, 3'd4, 1'b0, 1'b0, 0);
        send_sample(16'sd7, 3'd5, 1'b0, 1'b0, 0);
        send_sample(16'sh7FFF, 3'd5, 1'b1, 1'b1, 0);
        send_sample(-16'sd12345, 3'd6, 1'b0, 1'b0, 0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            style = tap_style_t'(ph % 3);
            write_all(pick_tap(style), pick_tap(style), pick_tap(style),
                      pick_tap(style), pick_tap(style), pick_wet(ph));
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (quiet > 0)
                begin
                    quiet--;
                    gap = 0;
                end
                else if ($urandom_range(0, 49) == 0)
                begin
                    quiet = $urandom_range(20, 60);
                    gap   = 0;
                end
                else
                    gap = idle_len();
                send_sample(pick_sample(), CH_W'($urandom_range(0, N_CH - 1)),
                            $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0, gap);
            end
        end

        drain();
        repeat (20) @(posedge clk);

        $display("Checked %0d filtered beats over %0d tap/mix settings plus reset values.",
                 bank.checked, settings_used);
        $display("%0d beats hit the accumulator clamp, %0d went out bypassed.",
                 bank.clamped, bypassed);
        if (bank.faults == 0 && bank.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
